[hdl/ir_uart_burst_transmitter_top_macros.svh]
// Assertion helpers for the burst transmitter checker.
`ifndef IR_UART_BURST_TRANSMITTER_TOP_MACROS_SVH
`define IR_UART_BURST_TRANSMITTER_TOP_MACROS_SVH

// Clocked assertion, quiet while reset is held.
`define IRUB_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Clocked assertion that also holds during reset.
`define IRUB_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

[hdl/irub_pkg.sv]
package irub_pkg;

  // Configuration register indexes.
  typedef enum logic [2:0] {
    CFG_DEVICE_ID      = 3'd0,
    CFG_MAGAZINE_SIZE  = 3'd1,
    CFG_BURST_FRAMES   = 3'd2,
    CFG_TRIGGER_DIVIDE = 3'd3,
    CFG_GAP_TICKS      = 3'd4
  } cfg_reg_t;

  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = 16;
  localparam int COUNT_W     = 16;
  localparam int LED_W       = 5;
  localparam int PHASE_W     = 5;

  // Frame phase codes; gap phases are PHASE_GAP plus ticks remaining.
  localparam logic [PHASE_W-1:0] PHASE_START     = 5'd0;
  localparam logic [PHASE_W-1:0] PHASE_DATA_LAST = 5'd8;
  localparam logic [PHASE_W-1:0] PHASE_PARITY    = 5'd9;
  localparam logic [PHASE_W-1:0] PHASE_STOP      = 5'd10;
  localparam logic [PHASE_W-1:0] PHASE_GAP       = 5'd16;
  localparam logic [PHASE_W-1:0] PHASE_GAP_LAST  = 5'd17;

  // Reset values.
  localparam logic [7:0]         RST_DEVICE_ID      = 8'd3;
  localparam logic [COUNT_W-1:0] RST_MAGAZINE_SIZE  = 16'd1000;
  localparam logic [7:0]         RST_BURST_FRAMES   = 8'd40;
  localparam logic [7:0]         RST_TRIGGER_DIVIDE = 8'd120;
  localparam logic [3:0]         RST_GAP_TICKS      = 4'd4;
  localparam logic [LED_W-1:0]   RST_LEDS           = 5'h1F;

endpackage

[hdl/irub_led_bar.sv]
// Pick the LED pin to drop for a bullet count against fifths of the magazine.
module irub_led_bar
  import irub_pkg::*;
(
  input  logic [COUNT_W-1:0] count,
  input  logic [COUNT_W-1:0] magazine,
  output logic [LED_W-1:0]   clear_mask
);

  logic [COUNT_W+2:0] five_b;
  logic [COUNT_W+2:0] m1;
  logic [COUNT_W+2:0] m2;
  logic [COUNT_W+2:0] m3;
  logic [COUNT_W+2:0] m4;

  // Scale count by five and magazine by one to four with shifts and adds
  assign five_b = {1'b0, count, 2'b00} + {3'b000, count};
  assign m1     = {3'b000, magazine};
  assign m2     = {2'b00, magazine, 1'b0};
  assign m3     = m2 + m1;
  assign m4     = {1'b0, magazine, 2'b00};

  // Priority: empty first, then the lowest fifth reached
  always_comb begin
    clear_mask = '0;
    if (count == '0) begin
      clear_mask[4] = 1'b1;
    end else if (five_b < m1) begin
      clear_mask[3] = 1'b1;
    end else if (five_b < m2) begin
      clear_mask[2] = 1'b1;
    end else if (five_b < m3) begin
      clear_mask[1] = 1'b1;
    end else if (five_b < m4) begin
      clear_mask[0] = 1'b1;
    end
  end

endmodule

[hdl/ir_uart_burst_transmitter_top.sv]
// Infrared burst transmitter with 8E1 framing. Each input transaction is one
// bit-time tick carrying the raw trigger level and yields exactly one result
// transaction holding the carrier enable, LED pins, bullet count and burst
// flag after that tick. One tick is taken per clock: the result appears in the
// cycle after acceptance in the state register bank, which doubles as the
// output register, and a new tick is accepted in the same cycle the previous
// result is taken. Only out_stall holding a pending result stalls the input.
// The user writes registers through the cfg port only while the block is idle;
// the block does not enforce this. No clearing pass is needed after reset.
module ir_uart_burst_transmitter_top
  import irub_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  logic                   in_trigger_level,
  output logic                   out_valid,
  input  logic                   out_stall,
  output logic                   out_carrier_on,
  output logic [LED_W-1:0]       out_led_pins,
  output logic [COUNT_W-1:0]     out_bullets_left,
  output logic                   out_burst_active,
  input  logic                   cfg_we,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data
);

  logic [7:0]         device_id_r;
  logic [COUNT_W-1:0] magazine_size_r;
  logic [7:0]         burst_frames_r;
  logic [7:0]         trigger_divide_r;
  logic [3:0]         gap_ticks_r;

  logic [7:0]         sample_count_r, sample_count_nxt;
  logic               prev_trigger_r, prev_trigger_nxt;
  logic               active_r, active_nxt;
  logic [PHASE_W-1:0] phase_r, phase_nxt;
  logic [7:0]         frames_left_r, frames_left_nxt;
  logic [COUNT_W-1:0] bullet_r, bullet_nxt;
  logic [LED_W-1:0]   led_r, led_nxt;
  logic               carrier_r, carrier_nxt;
  logic               out_valid_r;

  logic               accept;
  logic               sample_now;
  logic               active_start;
  logic [2:0]         data_bit;
  logic [7:0]         frames_dec;
  logic [LED_W-1:0]   clear_mask;

  // Hold the input only while a result is waiting and stalled
  assign in_stall = out_valid_r && out_stall;
  assign accept   = in_valid && !in_stall;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      device_id_r      <= RST_DEVICE_ID;
      magazine_size_r  <= RST_MAGAZINE_SIZE;
      burst_frames_r   <= RST_BURST_FRAMES;
      trigger_divide_r <= RST_TRIGGER_DIVIDE;
      gap_ticks_r      <= RST_GAP_TICKS;
    end else if (cfg_we) begin
      case (cfg_reg_t'(cfg_index))
        CFG_DEVICE_ID:      device_id_r      <= cfg_data[7:0];
        CFG_MAGAZINE_SIZE:  magazine_size_r  <= cfg_data;
        CFG_BURST_FRAMES:   burst_frames_r   <= cfg_data[7:0];
        CFG_TRIGGER_DIVIDE: trigger_divide_r <= cfg_data[7:0];
        CFG_GAP_TICKS:      gap_ticks_r      <= cfg_data[3:0];
        default: ;
      endcase
    end
  end

  // Sample the trigger and detect a press edge
  assign sample_now   = (sample_count_r >= trigger_divide_r);
  assign active_start = sample_now && !in_trigger_level && prev_trigger_r &&
                        (bullet_r != '0);
  assign data_bit     = phase_r[2:0] - 3'd1;
  assign frames_dec   = (frames_left_r != '0) ? frames_left_r - 8'd1 : frames_left_r;

  irub_led_bar u_led_bar (
    .count      (bullet_nxt),
    .magazine   (magazine_size_r),
    .clear_mask (clear_mask)
  );

  // Next tick: sampling, frame sequencing, bullets and LEDs
  always_comb begin
    sample_count_nxt = (sample_now ? 8'd0 : sample_count_r) + 8'd1;
    prev_trigger_nxt = sample_now ? in_trigger_level : prev_trigger_r;
    active_nxt       = active_r || active_start;
    phase_nxt        = phase_r;
    frames_left_nxt  = frames_left_r;
    bullet_nxt       = bullet_r;
    carrier_nxt      = carrier_r;
    led_nxt          = led_r;
    if (active_r || active_start) begin
      if (phase_r >= 5'd1 && phase_r <= PHASE_DATA_LAST) begin
        carrier_nxt = !device_id_r[data_bit];
        phase_nxt   = phase_r + 5'd1;
      end else if (phase_r == PHASE_PARITY) begin
        carrier_nxt = !(^device_id_r);
        phase_nxt   = PHASE_STOP;
      end else if (phase_r == PHASE_STOP) begin
        carrier_nxt = 1'b0;
        phase_nxt   = (gap_ticks_r == '0) ? PHASE_START : {1'b1, gap_ticks_r};
        if (bullet_r != '0) begin
          bullet_nxt = bullet_r - 16'd1;
        end
        frames_left_nxt = frames_dec;
        if (frames_dec == '0) begin
          active_nxt      = 1'b0;
          frames_left_nxt = burst_frames_r;
        end
      end else if (phase_r > PHASE_GAP) begin
        phase_nxt = (phase_r == PHASE_GAP_LAST) ? PHASE_START : phase_r - 5'd1;
      end else begin
        // start bit, also for unused codes
        carrier_nxt = 1'b1;
        phase_nxt   = 5'd1;
      end
      led_nxt = led_r & ~clear_mask;
    end
  end

  // Advance state on each accepted transaction; state is the result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sample_count_r <= '0;
      prev_trigger_r <= 1'b0;
      active_r       <= 1'b0;
      phase_r        <= PHASE_START;
      frames_left_r  <= RST_BURST_FRAMES;
      bullet_r       <= RST_MAGAZINE_SIZE;
      led_r          <= RST_LEDS;
      carrier_r      <= 1'b0;
      out_valid_r    <= 1'b0;
    end else begin
      if (accept) begin
        sample_count_r <= sample_count_nxt;
        prev_trigger_r <= prev_trigger_nxt;
        active_r       <= active_nxt;
        phase_r        <= phase_nxt;
        frames_left_r  <= frames_left_nxt;
        bullet_r       <= bullet_nxt;
        led_r          <= led_nxt;
        carrier_r      <= carrier_nxt;
      end
      if (accept) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_valid        = out_valid_r;
  assign out_carrier_on   = carrier_r;
  assign out_led_pins     = led_r;
  assign out_bullets_left = bullet_r;
  assign out_burst_active = active_r;

endmodule

[hdl/irub_checker.sv]
`include "ir_uart_burst_transmitter_top_macros.svh"

// Port-level checks on the burst transmitter.
module irub_checker
  import irub_pkg::*;
(
  input logic               clk,
  input logic               rst_n,
  input logic               out_valid,
  input logic               out_stall,
  input logic               out_carrier_on,
  input logic [LED_W-1:0]   out_led_pins,
  input logic [COUNT_W-1:0] out_bullets_left,
  input logic               out_burst_active
);

  logic [LED_W-1:0]   led_last_r;
  logic [COUNT_W-1:0] bullets_last_r;
  logic               out_take;

  assign out_take = out_valid && !out_stall;

  // Track the last delivered LED pins and bullet count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      led_last_r     <= RST_LEDS;
      bullets_last_r <= RST_MAGAZINE_SIZE;
    end else if (out_take) begin
      led_last_r     <= out_led_pins;
      bullets_last_r <= out_bullets_left;
    end
  end

  `IRUB_ASSERT(a_stall_holds, out_valid && out_stall |=> out_valid && $stable(out_led_pins) && $stable(out_bullets_left), "stalled result changed")
  `IRUB_ASSERT(a_carrier_in_burst, out_valid && out_carrier_on |-> out_burst_active, "carrier on outside a burst")
  `IRUB_ASSERT_ALWAYS(a_leds_latch, out_take |-> (out_led_pins & ~led_last_r) == '0, "LED pin set again")
  `IRUB_ASSERT_ALWAYS(a_bullets_fall, out_take |-> out_bullets_left <= bullets_last_r, "bullet count rose")
  `IRUB_ASSERT(a_empty_led, out_valid && out_bullets_left == '0 |-> !out_led_pins[4], "empty magazine with LED four lit")

endmodule

bind ir_uart_burst_transmitter_top irub_checker u_irub_checker (.*);

[tb/tb_top.sv]
`timescale 1ns / 100ps

module tb_top;
  import irub_pkg::*;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int MAX_IDLE       = 12;
  localparam int RANDOM_TICKS   = 1200;

  // One result transaction: line and indicator state after a tick
  typedef struct packed {
    logic               carrier_on;
    logic [LED_W-1:0]   led_pins;
    logic [COUNT_W-1:0] bullets_left;
    logic               burst_active;
  } tick_result_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic                   in_valid = 1'b0;
  logic                   in_stall;
  logic                   in_trigger_level = 1'b1;
  logic                   out_valid;
  logic                   out_stall = 1'b0;
  logic                   out_carrier_on;
  logic [LED_W-1:0]       out_led_pins;
  logic [COUNT_W-1:0]     out_bullets_left;
  logic                   out_burst_active;
  logic                   cfg_we = 1'b0;
  logic [CFG_INDEX_W-1:0] cfg_index = CFG_DEVICE_ID;
  logic [CFG_DATA_W-1:0]  cfg_data = '0;

  // Transmitter settings as last written
  logic [7:0]         r_device_id;
  logic [COUNT_W-1:0] r_magazine;
  logic [7:0]         r_burst_frames;
  logic [7:0]         r_trig_div;
  logic [3:0]         r_gap;

  // Transmitter state tracked alongside the block
  logic [7:0]         m_sample_cnt;
  logic               m_prev;
  logic               m_active;
  logic [PHASE_W-1:0] m_phase;
  logic [7:0]         m_frames_left;
  logic [COUNT_W-1:0] m_bullets;
  logic [LED_W-1:0]   m_leds;
  logic               m_carrier;

  tick_result_t pending_ticks[$];

  bit          send_idle_on = 1'b1;
  bit          recv_idle_on = 1'b1;
  int unsigned error_count = 0;
  int unsigned ticks_sent = 0;
  int unsigned results_checked = 0;
  int unsigned bursts_started = 0;
  int unsigned settings_written = 0;
  int unsigned quiet_cycles = 0;

  ir_uart_burst_transmitter_top uut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_trigger_level (in_trigger_level),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_carrier_on   (out_carrier_on),
    .out_led_pins     (out_led_pins),
    .out_bullets_left (out_bullets_left),
    .out_burst_active (out_burst_active),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Advance the transmitter by one tick and queue the state it should show
  function automatic void step_transmitter(input logic level);
    tick_result_t res;
    logic [PHASE_W-1:0] ph;
    int unsigned five_b;
    int unsigned mag;
    if (m_sample_cnt >= r_trig_div) begin
      if (!level && m_prev && m_bullets != 0) begin
        if (!m_active) bursts_started++;
        m_active = 1'b1;
      end
      m_prev = level;
      m_sample_cnt = '0;
    end
    m_sample_cnt = m_sample_cnt + 8'd1;

    if (m_active) begin
      // Frame sequencing: carrier on sends a zero on the line
      ph = m_phase;
      if (ph > PHASE_START && ph <= PHASE_DATA_LAST) begin
        m_carrier = ~r_device_id[ph - 5'd1];
        m_phase = ph + 5'd1;
      end else if (ph == PHASE_PARITY) begin
        m_carrier = ~(^r_device_id);
        m_phase = PHASE_STOP;
      end else if (ph == PHASE_STOP) begin
        m_carrier = 1'b0;
        m_phase = (r_gap == 4'd0) ? PHASE_START : PHASE_GAP + {1'b0, r_gap};
        if (m_bullets != 0) m_bullets = m_bullets - 16'd1;
        if (m_frames_left != 0) m_frames_left = m_frames_left - 8'd1;
        if (m_frames_left == 0) begin
          m_active = 1'b0;
          m_frames_left = r_burst_frames;
        end
      end else if (ph > PHASE_GAP) begin
        m_phase = (ph == PHASE_GAP_LAST) ? PHASE_START : ph - 5'd1;
      end else begin
        // start bit, also for the unused codes
        m_carrier = 1'b1;
        m_phase = PHASE_START + 5'd1;
      end

      // Latch LED pins low as the count drops through the fifths
      five_b = m_bullets * 32'd5;
      mag = r_magazine;
      if (m_bullets == 0) m_leds[4] = 1'b0;
      else if (five_b < mag) m_leds[3] = 1'b0;
      else if (five_b < 2 * mag) m_leds[2] = 1'b0;
      else if (five_b < 3 * mag) m_leds[1] = 1'b0;
      else if (five_b < 4 * mag) m_leds[0] = 1'b0;
    end

    res.carrier_on = m_carrier;
    res.led_pins = m_leds;
    res.bullets_left = m_bullets;
    res.burst_active = m_active;
    pending_ticks.push_back(res);
  endfunction

  // Send one tick transaction; hold the payload until it is taken
  task automatic send_tick(input logic level);
    int unsigned pause;
    pause = send_idle_on ? $urandom_range(0, MAX_IDLE) : 0;
    if (pause != 0) begin
      in_valid <= 1'b0;
      repeat (pause) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_trigger_level <= level;
    do @(posedge clk); while (in_stall);
    step_transmitter(level);
    ticks_sent++;
  endtask

  // Stop sending and wait for every queued result
  task automatic drain_results();
    in_valid <= 1'b0;
    while (pending_ticks.size() != 0) @(posedge clk);
  endtask

  // Write all five registers back to back; upper data bits of the narrow ones carry junk
  task automatic write_config(input logic [7:0] id, input logic [15:0] mag,
                              input logic [7:0] frames, input logic [7:0] div,
                              input logic [3:0] gap);
    cfg_we <= 1'b1;
    cfg_index <= CFG_DEVICE_ID;
    cfg_data <= {8'($urandom), id};
    @(posedge clk);
    cfg_index <= CFG_MAGAZINE_SIZE;
    cfg_data <= mag;
    @(posedge clk);
    cfg_index <= CFG_BURST_FRAMES;
    cfg_data <= {8'($urandom), frames};
    @(posedge clk);
    cfg_index <= CFG_TRIGGER_DIVIDE;
    cfg_data <= {8'($urandom), div};
    @(posedge clk);
    cfg_index <= CFG_GAP_TICKS;
    cfg_data <= {12'($urandom), gap};
    @(posedge clk);
    cfg_we <= 1'b0;
    r_device_id = id;
    r_magazine = mag;
    r_burst_frames = frames;
    r_trig_div = div;
    r_gap = gap;
    settings_written++;
  endtask

  // Release long enough for one sample, press for one, then ride out the burst
  task automatic fire_burst(input bit toggle);
    int unsigned span;
    span = int'(r_trig_div) + 1;
    repeat (span) send_tick(1'b1);
    repeat (span) send_tick(1'b0);
    while (m_active) send_tick(toggle ? 1'($urandom_range(0, 1)) : 1'b0);
  endtask

  task automatic test_reset_state();
    repeat (8) send_tick(1'b1);
    drain_results();
  endtask

  // All-ones and mixed data, gap extremes, sampling on every tick
  task automatic test_frame_format();
    write_config(8'hFF, 16'd65535, 8'd1, 8'd0, 4'd0);
    fire_burst(1'b0);
    drain_results();
    write_config(8'hA5, 16'd1, 8'd2, 8'd1, 4'd15);
    fire_burst(1'b0);
    drain_results();
  endtask

  // A zero frame count takes effect at the next reload and yields one frame
  task automatic test_zero_frames_reload();
    write_config(8'h00, 16'd1000, 8'd0, 8'd1, 4'd1);
    fire_burst(1'b0);
    fire_burst(1'b0);
    drain_results();
  endtask

  // Trigger edges inside a burst are ignored
  task automatic test_retrigger_during_burst();
    write_config(8'h96, 16'd1000, 8'd3, 8'd0, 4'd2);
    fire_burst(1'b1);
    drain_results();
  endtask

  task automatic test_slow_sampling();
    write_config(8'h5A, 16'd1000, 8'd1, 8'd255, 4'd4);
    fire_burst(1'b0);
    drain_results();
  endtask

  // Random settings; mostly clean presses, some noise and short presses
  task automatic test_random_traffic();
    int unsigned first_tick;
    int unsigned pick;
    int unsigned mag;
    int unsigned span;
    logic [7:0]  div;
    logic [7:0]  frames;
    first_tick = ticks_sent;
    while (ticks_sent - first_tick < RANDOM_TICKS) begin
      drain_results();
      pick = $urandom_range(0, 4);
      case (pick)
        0: mag = (10 * int'(m_bullets)) / 7;
        1: mag = 2 * int'(m_bullets);
        2: mag = (10 * int'(m_bullets)) / 3;
        3: mag = 10 * int'(m_bullets);
        default: mag = $urandom_range(1, 65535);
      endcase
      if (mag == 0) mag = 1;
      if (mag > 65535) mag = 65535;
      div = ($urandom_range(0, 15) == 0) ? 8'($urandom_range(7, 255))
                                         : 8'($urandom_range(0, 6));
      frames = ($urandom_range(0, 9) == 0) ? 8'($urandom_range(0, 12))
                                           : 8'($urandom_range(1, 5));
      write_config(8'($urandom), 16'(mag), frames, div, 4'($urandom));
      send_idle_on = ($urandom_range(0, 2) != 0);
      recv_idle_on = ($urandom_range(0, 2) != 0);
      span = int'(r_trig_div) + 1;
      repeat ($urandom_range(1, 3)) begin
        pick = $urandom_range(0, 9);
        if (pick <= 5) begin
          fire_burst(1'($urandom_range(0, 1)));
        end else if (pick <= 7) begin
          repeat ($urandom_range(1, 24)) send_tick(1'($urandom_range(0, 1)));
        end else begin
          repeat (span) send_tick(1'b1);
          repeat ($urandom_range(1, span)) send_tick(1'b0);
        end
      end
    end
    send_idle_on = 1'b1;
    recv_idle_on = 1'b1;
  endtask

  // Run the count to zero with a burst still under way, then pull on empty
  task automatic test_empty_magazine();
    int unsigned first_len;
    int unsigned rest;
    logic [7:0]  frames;
    drain_results();
    first_len = (m_frames_left == 0) ? 1 : m_frames_left;
    rest = (m_bullets > first_len) ? m_bullets - first_len : 0;
    frames = (rest % 255 == 0) ? 8'd254 : 8'd255;
    write_config(8'($urandom), (m_bullets == 0) ? 16'd1 : m_bullets, frames, 8'd1,
                 4'($urandom_range(0, 2)));
    while (m_bullets != 0) fire_burst(1'b0);
    fire_burst(1'b1);
    repeat (40) send_tick(1'($urandom_range(0, 1)));
    drain_results();
  endtask

  // Result side: draw a stall per transaction, then take one
  initial begin : result_sink
    int unsigned hold;
    forever begin
      hold = recv_idle_on ? $urandom_range(0, MAX_IDLE) : 0;
      if (hold != 0) begin
        out_stall <= 1'b1;
        repeat (hold) @(posedge clk);
      end
      out_stall <= 1'b0;
      @(posedge clk);
      while (!(rst_n && out_valid)) @(posedge clk);
    end
  end

  // Compare each taken result with the oldest expectation
  always @(posedge clk) begin : result_check
    tick_result_t exp_res;
    if (rst_n && out_valid && !out_stall) begin
      results_checked++;
      if (pending_ticks.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual carrier %0d leds %b count %0d active %0d",
                 $time, out_carrier_on, out_led_pins, out_bullets_left, out_burst_active);
        error_count++;
      end else begin
        exp_res = pending_ticks.pop_front();
        if (out_carrier_on !== exp_res.carrier_on) begin
          $display("%0t: carrier_on mismatch, expected %0d, actual %0d",
                   $time, exp_res.carrier_on, out_carrier_on);
          error_count++;
        end
        if (out_led_pins !== exp_res.led_pins) begin
          $display("%0t: led_pins mismatch, expected %b, actual %b",
                   $time, exp_res.led_pins, out_led_pins);
          error_count++;
        end
        if (out_bullets_left !== exp_res.bullets_left) begin
          $display("%0t: bullets_left mismatch, expected %0d, actual %0d",
                   $time, exp_res.bullets_left, out_bullets_left);
          error_count++;
        end
        if (out_burst_active !== exp_res.burst_active) begin
          $display("%0t: burst_active mismatch, expected %0d, actual %0d",
                   $time, exp_res.burst_active, out_burst_active);
          error_count++;
        end
      end
    end
  end

  // Abort when no transaction moves on either side for too long
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t: no transaction for %0d cycles", $time, quiet_cycles);
      $display("FAIL ir_uart_burst_transmitter_top");
      $finish;
    end
  end

  initial begin
    // Settings and state as after reset
    r_device_id = RST_DEVICE_ID;
    r_magazine = RST_MAGAZINE_SIZE;
    r_burst_frames = RST_BURST_FRAMES;
    r_trig_div = RST_TRIGGER_DIVIDE;
    r_gap = RST_GAP_TICKS;
    m_sample_cnt = '0;
    m_prev = 1'b0;
    m_active = 1'b0;
    m_phase = PHASE_START;
    m_frames_left = RST_BURST_FRAMES;
    m_bullets = RST_MAGAZINE_SIZE;
    m_leds = RST_LEDS;
    m_carrier = 1'b0;

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_reset_state();
    test_frame_format();
    test_zero_frames_reload();
    test_retrigger_during_burst();
    test_slow_sampling();
    test_random_traffic();
    test_empty_magazine();

    drain_results();
    repeat (20) @(posedge clk);
    if (pending_ticks.size() != 0) begin
      $display("%0t: %0d results never arrived, expected 0 outstanding, actual %0d",
               $time, pending_ticks.size(), pending_ticks.size());
      error_count++;
    end

    $display("Sent %0d trigger ticks and checked %0d results over %0d register settings.",
             ticks_sent, results_checked, settings_written);
    $display("Started %0d bursts; final count %0d, LED pins %b, %0d mismatches.",
             bursts_started, m_bullets, m_leds, error_count);
    if (error_count == 0) begin
      $display("PASS ir_uart_burst_transmitter_top");
    end else begin
      $display("FAIL ir_uart_burst_transmitter_top");
    end
    $finish;
  end

endmodule

[filelist.f]
+incdir+hdl
hdl/irub_pkg.sv
hdl/irub_led_bar.sv
hdl/ir_uart_burst_transmitter_top.sv
hdl/irub_checker.sv
tb/tb_top.sv
